// ===== rtl/core/arctan_degrees_unit_assert.svh =====
// Assertion macros used by the arctan degrees unit checker
`ifndef ARCTAN_DEGREES_UNIT_ASSERT_SVH
`define ARCTAN_DEGREES_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ADU_ASSERT_IMP(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ADU_ASSERT_NXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/adu_pkg.sv =====
// Types, constants and angle table function for the arctan degrees unit
`timescale 1ns / 1ps

package adu_pkg;

	localparam int DW = 64;
	localparam int ZW = 35;
	localparam int ANG_FRAC = 24;
	localparam int OUT_W = 25;

	localparam logic signed [63:0] DEG_PER_RAD_Q24 = 64'sd961263669;
	localparam logic signed [ZW-1:0] DEG180_Q24 = 35'sd3019898880;
	localparam logic signed [ZW-1:0] DEG45_Q24 = 35'sd754974720;
	localparam logic signed [ZW-1:0] ROUND_HALF = 35'sd128;
	localparam logic signed [OUT_W-1:0] DEG90_Q16 = 25'sd5898240;
	localparam logic signed [OUT_W-1:0] DEG180_Q16 = 25'sd11796480;
	localparam logic signed [32:0] ONE_Q16 = 33'sd65536;

	typedef enum logic [2:0] {
		KIND_UNARY  = 3'd0,
		KIND_BINARY = 3'd1,
		KIND_POS90  = 3'd2,
		KIND_NEG90  = 3'd3,
		KIND_ZERO   = 3'd4,
		KIND_POS180 = 3'd5
	} kind_t;

	function automatic logic signed [63:0] odd_div(input logic signed [63:0] v,
		input int unsigned k);
		case (k)
			0:  odd_div = v;
			1:  odd_div = v / 3;
			2:  odd_div = v / 5;
			3:  odd_div = v / 7;
			4:  odd_div = v / 9;
			5:  odd_div = v / 11;
			6:  odd_div = v / 13;
			7:  odd_div = v / 15;
			8:  odd_div = v / 17;
			9:  odd_div = v / 19;
			10: odd_div = v / 21;
			11: odd_div = v / 23;
			12: odd_div = v / 25;
			13: odd_div = v / 27;
			14: odd_div = v / 29;
			15: odd_div = v / 31;
			16: odd_div = v / 33;
			17: odd_div = v / 35;
			18: odd_div = v / 37;
			19: odd_div = v / 39;
			20: odd_div = v / 41;
			21: odd_div = v / 43;
			22: odd_div = v / 45;
			23: odd_div = v / 47;
			24: odd_div = v / 49;
			default: odd_div = '0;
		endcase
	endfunction

	// atan(2^-i) in degrees, Q.24, from the odd power series
	function automatic logic signed [ZW-1:0] step_angle(input int unsigned i);
		logic signed [63:0] base;
		logic signed [63:0] acc;
		logic signed [63:0] t;
		int unsigned sh;
		base = DEG_PER_RAD_Q24 <<< 20;
		acc = '0;
		if (i == 0) begin
			return DEG45_Q24;
		end
		for (int unsigned k = 0; k < 25; k++) begin
			sh = i * (2 * k + 1);
			t = (sh > 62) ? 64'sd0 : odd_div(base >>> sh, k);
			acc = k[0] ? acc - t : acc + t;
		end
		return ZW'((acc + (64'sd1 <<< 19)) >>> 20);
	endfunction

endpackage

// ===== rtl/core/adu_in_if.sv =====
// Request channel of the arctan degrees unit
`timescale 1ns / 1ps

interface adu_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic signed [31:0] first_value;
	logic signed [31:0] second_value;

	modport source (output valid, func, first_value, second_value, input ready);
	modport sink (input valid, func, first_value, second_value, output ready);
endinterface

// ===== rtl/core/adu_out_if.sv =====
// Result channel of the arctan degrees unit
`timescale 1ns / 1ps

interface adu_out_if;
	logic               valid;
	logic               ready;
	logic signed [24:0] angle_deg;

	modport source (output valid, angle_deg, input ready);
	modport sink (input valid, angle_deg, output ready);
endinterface

// ===== rtl/core/arctan_degrees_unit.sv =====
// Pipelined CORDIC arctangent / atan2 in degrees, Q16.16 in, Q9.16 out
`timescale 1ns / 1ps

// Usage:
//   req: valid/ready request channel with func, first_value, second_value.
//     func 0 gives atan(first_value); func 1 gives atan2(second_value, first_value).
//   rsp: valid/ready result channel with angle_deg, signed Q9.16 degrees.
// Throughput: one request per cycle while rsp is not stalled; the pipeline holds up to
//   CORDIC_STEPS + 2 requests in flight.
// Stages: one operand setup stage, one stage per CORDIC micro-rotation, one rounding
//   and saturation stage that is also the output register.
// Stall: while rsp.valid is high and rsp.ready is low, every stage holds and
//   req.ready is low; nothing is dropped or repeated.
// Reset: arst_n clears all valid bits at once; the block takes requests in the
//   first cycle after reset is released.
module arctan_degrees_unit #(
	parameter int CORDIC_STEPS = 20
) (
	input logic       clk,
	input logic       arst_n,
	adu_in_if.sink    req,
	adu_out_if.source rsp
);

	localparam int NS = CORDIC_STEPS;
	localparam int DW = adu_pkg::DW;
	localparam int ZW = adu_pkg::ZW;
	localparam int OUT_W = adu_pkg::OUT_W;
	localparam int SW = ZW - 8;

	logic adv;

	logic signed [32:0]  a_ext;
	logic signed [32:0]  b_ext;
	logic signed [32:0]  x_pre;
	logic signed [32:0]  y_pre;
	logic signed [ZW-1:0] z_pre;
	adu_pkg::kind_t      kind_pre;

	logic [NS:0]          v_s;
	logic signed [DW-1:0] x_s [0:NS-1];
	logic signed [DW-1:0] y_s [0:NS-1];
	logic signed [ZW-1:0] z_s [0:NS];
	adu_pkg::kind_t       kind_s [0:NS];

	logic signed [ZW-1:0]    z_rnd;
	logic signed [SW-1:0]    z_q16;
	logic signed [SW-1:0]    lim;
	logic signed [OUT_W-1:0] sat;
	logic signed [OUT_W-1:0] res;

	logic                    vout_s;
	logic signed [OUT_W-1:0] angle_s;

	assign adv = !vout_s || rsp.ready;
	assign req.ready = adv;

	assign a_ext = 33'(req.first_value);
	assign b_ext = 33'(req.second_value);

	always_comb begin
		x_pre = a_ext;
		y_pre = b_ext;
		z_pre = '0;
		kind_pre = adu_pkg::KIND_BINARY;
		if (!req.func) begin
			kind_pre = adu_pkg::KIND_UNARY;
			x_pre = adu_pkg::ONE_Q16;
			y_pre = a_ext;
		end else if (req.first_value == '0) begin
			kind_pre = b_ext[32] ? adu_pkg::KIND_NEG90 : adu_pkg::KIND_POS90;
		end else if (req.second_value == '0) begin
			kind_pre = a_ext[32] ? adu_pkg::KIND_POS180 : adu_pkg::KIND_ZERO;
		end else if (a_ext[32]) begin
			x_pre = -a_ext;
			y_pre = -b_ext;
			z_pre = b_ext[32] ? -adu_pkg::DEG180_Q24 : adu_pkg::DEG180_Q24;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else if (adv) begin
			v_s <= {v_s[NS-1:0], req.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s[0] <= DW'(x_pre) <<< 30;
			y_s[0] <= DW'(y_pre) <<< 30;
			z_s[0] <= z_pre;
			kind_s[0] <= kind_pre;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_rot
		localparam logic signed [ZW-1:0] ANG = adu_pkg::step_angle(k);
		logic y_neg;
		assign y_neg = y_s[k][DW-1];

		always_ff @(posedge clk) begin
			if (adv) begin
				z_s[k+1] <= y_neg ? z_s[k] - ANG : z_s[k] + ANG;
				kind_s[k+1] <= kind_s[k];
			end
		end

		if (k < NS - 1) begin : g_xy
			always_ff @(posedge clk) begin
				if (adv) begin
					x_s[k+1] <= y_neg ? x_s[k] - (y_s[k] >>> k) : x_s[k] + (y_s[k] >>> k);
					y_s[k+1] <= y_neg ? y_s[k] + (x_s[k] >>> k) : y_s[k] - (x_s[k] >>> k);
				end
			end
		end
	end

	always_comb begin
		z_rnd = z_s[NS] + adu_pkg::ROUND_HALF;
		z_q16 = z_rnd[ZW-1:8];
		lim = (kind_s[NS] == adu_pkg::KIND_UNARY) ? SW'(adu_pkg::DEG90_Q16)
			: SW'(adu_pkg::DEG180_Q16);
		if (z_q16 > lim) begin
			sat = OUT_W'(lim);
		end else if (z_q16 < -lim) begin
			sat = OUT_W'(-lim);
		end else begin
			sat = OUT_W'(z_q16);
		end
		unique case (kind_s[NS]) inside
			adu_pkg::KIND_UNARY, adu_pkg::KIND_BINARY: res = sat;
			adu_pkg::KIND_POS90:  res = adu_pkg::DEG90_Q16;
			adu_pkg::KIND_NEG90:  res = -adu_pkg::DEG90_Q16;
			adu_pkg::KIND_ZERO:   res = '0;
			adu_pkg::KIND_POS180: res = adu_pkg::DEG180_Q16;
			default:              res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vout_s <= 1'b0;
		end else if (adv) begin
			vout_s <= v_s[NS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			angle_s <= res;
		end
	end

	assign rsp.valid = vout_s;
	assign rsp.angle_deg = angle_s;

endmodule

// ===== rtl/core/adu_checker.sv =====
// Port-level checker for the arctan degrees unit, with its bind
`timescale 1ns / 1ps
`include "arctan_degrees_unit_assert.svh"

module adu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [24:0] angle_deg
);

	`ADU_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
	`ADU_ASSERT_NXT(a_rsp_stable, clk, arst_n, rsp_valid && !rsp_ready, $stable(angle_deg), "result changed while stalled")
	`ADU_ASSERT_IMP(a_ready_flow, clk, arst_n, 1'b1, req_ready == (!rsp_valid || rsp_ready), "request ready does not follow result backpressure")
	`ADU_ASSERT_IMP(a_range, clk, arst_n, rsp_valid, ($signed(angle_deg) <= 25'sd11796480) && ($signed(angle_deg) >= -25'sd11796480), "angle outside -180..180 degrees")

endmodule

bind arctan_degrees_unit adu_checker u_adu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.angle_deg (rsp.angle_deg)
);

// ===== dv/tb_top.sv =====
// Testbench for arctan_degrees_unit: directed and random requests, with their angles checked
`timescale 1ns / 1ps

module tb_top;

	localparam int STEPS = 20;
	localparam logic FUNC_ATAN = 1'b0;
	localparam logic FUNC_ATAN2 = 1'b1;
	localparam longint RAD_TO_DEG_Q24 = 64'sd961263669;
	localparam longint RIGHT_ANGLE_Q16 = 64'sd5898240;
	localparam longint HALF_TURN_Q16 = 64'sd11796480;
	localparam longint HALF_TURN_Q24 = 64'sd180 <<< 24;
	localparam int RANDOM_REQS = 1826;
	localparam int QUIET_TAIL = 250;
	localparam int LONG_HOLD_AT = 600;
	localparam int LONG_HOLD_CYCLES = 80;
	localparam int DRAIN_AT = 1000;
	localparam int SETTLE_CYCLES = STEPS + 10;

	typedef struct {
		logic               func;
		logic signed [31:0] first_value;
		logic signed [31:0] second_value;
		bit                 hold_for_drain;
	} atan_req_t;

	logic clk;
	logic arst_n;

	adu_in_if req();
	adu_out_if rsp();

	arctan_degrees_unit #(
		.CORDIC_STEPS(STEPS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp)
	);

	atan_req_t pending_reqs[$];
	logic signed [24:0] expected_angles[$];
	logic signed [24:0] angle_want;
	int total_reqs;
	int accepted_cnt;
	int fail_cnt;
	int send_gap;
	int send_phase_cnt;
	bit send_idle_ok;
	int hold_cnt;
	int rcv_phase_cnt;
	bit rcv_idle_ok;
	bit long_hold_done;
	bit quiet;

	assign quiet = accepted_cnt >= total_reqs - QUIET_TAIL;

	// atan(2^-i) in degrees, 24 fraction bits, from the odd power series
	function automatic longint micro_angle(input int i);
		longint base;
		longint acc;
		longint t;
		int sh;
		base = RAD_TO_DEG_Q24 <<< 20;
		acc = 0;
		if (i == 0) begin
			return 64'sd45 <<< 24;
		end
		for (int k = 0; k < 64; k++) begin
			sh = i * (2 * k + 1);
			if (sh > 62) begin
				break;
			end
			t = (base >>> sh) / longint'(2 * k + 1);
			if (t == 0) begin
				break;
			end
			acc = (k % 2 == 1) ? acc - t : acc + t;
		end
		return (acc + (64'sd1 <<< 19)) >>> 20;
	endfunction

	// heading of (x, y) with x > 0, degrees with 24 fraction bits
	function automatic longint heading_q24(input longint x, input longint y);
		longint z;
		longint dx;
		longint dy;
		z = 0;
		x = x <<< 30;
		y = y <<< 30;
		for (int i = 0; i < STEPS && i < 60; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + micro_angle(i);
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - micro_angle(i);
			end
		end
		return z;
	endfunction

	function automatic longint round_clamp(input longint z, input longint lim);
		longint v;
		v = (z + 128) >>> 8;
		if (v > lim) begin
			return lim;
		end
		if (v < -lim) begin
			return -lim;
		end
		return v;
	endfunction

	function automatic logic signed [24:0] predict_angle(input atan_req_t r);
		longint a;
		longint b;
		longint off;
		longint res;
		a = r.first_value;
		b = r.second_value;
		off = 0;
		if (r.func == FUNC_ATAN) begin
			res = round_clamp(heading_q24(64'sd65536, a), RIGHT_ANGLE_Q16);
		end else if (a == 0) begin
			res = (b < 0) ? -RIGHT_ANGLE_Q16 : RIGHT_ANGLE_Q16;
		end else if (b == 0) begin
			res = (a > 0) ? 0 : HALF_TURN_Q16;
		end else begin
			if (a < 0) begin
				off = (b < 0) ? -HALF_TURN_Q24 : HALF_TURN_Q24;
				a = -a;
				b = -b;
			end
			res = round_clamp(heading_q24(a, b) + off, HALF_TURN_Q16);
		end
		return res[24:0];
	endfunction

	function automatic logic [31:0] random_operand();
		logic [31:0] v;
		case ($urandom_range(0, 7))
			0, 1, 2: v = $urandom;
			3: v = $urandom_range(0, 511) - 256;
			4: v = '0;
			5: begin
				case ($urandom_range(0, 5))
					0: v = 32'h7fff_ffff;
					1: v = 32'h8000_0000;
					2: v = 32'h0001_0000;
					3: v = 32'hffff_0000;
					4: v = 32'h0000_0001;
					default: v = 32'hffff_ffff;
				endcase
			end
			default: v = $signed($urandom) >>> $urandom_range(0, 31);
		endcase
		return v;
	endfunction

	task automatic add_req(input logic func, input logic [31:0] a, input logic [31:0] b);
		atan_req_t r;
		r.func = func;
		r.first_value = a;
		r.second_value = b;
		r.hold_for_drain = (pending_reqs.size() == DRAIN_AT);
		pending_reqs.push_back(r);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;

		add_req(FUNC_ATAN, 32'h0000_0000, 32'hffff_ffff);
		add_req(FUNC_ATAN, 32'h0000_0001, 32'h0000_0000);
		add_req(FUNC_ATAN, 32'hffff_ffff, 32'h7fff_ffff);
		add_req(FUNC_ATAN, 32'h0001_0000, 32'h8000_0000);
		add_req(FUNC_ATAN, 32'hffff_0000, 32'h0000_0000);
		add_req(FUNC_ATAN, 32'h7fff_ffff, 32'h0000_0000);
		add_req(FUNC_ATAN, 32'h8000_0000, 32'hffff_ffff);
		// x zero: sign of y alone decides
		add_req(FUNC_ATAN2, 32'h0000_0000, 32'h0000_0000);
		add_req(FUNC_ATAN2, 32'h0000_0000, 32'h0001_0000);
		add_req(FUNC_ATAN2, 32'h0000_0000, 32'h8000_0000);
		// y zero: exact 0 or 180
		add_req(FUNC_ATAN2, 32'h0001_0000, 32'h0000_0000);
		add_req(FUNC_ATAN2, 32'h8000_0000, 32'h0000_0000);
		// x negative in both half planes, and full-scale operands
		add_req(FUNC_ATAN2, 32'hffff_0000, 32'h0001_0000);
		add_req(FUNC_ATAN2, 32'hffff_0000, 32'hffff_0000);
		add_req(FUNC_ATAN2, 32'h8000_0000, 32'h8000_0000);
		add_req(FUNC_ATAN2, 32'h7fff_ffff, 32'h7fff_ffff);
		add_req(FUNC_ATAN2, 32'h8000_0000, 32'h7fff_ffff);
		add_req(FUNC_ATAN2, 32'h7fff_ffff, 32'h8000_0000);
		// tiny operands
		add_req(FUNC_ATAN2, 32'h0000_0001, 32'h0000_0001);
		add_req(FUNC_ATAN2, 32'hffff_ffff, 32'hffff_ffff);
		add_req(FUNC_ATAN2, 32'h0000_0001, 32'hffff_ffff);
		// close to the half-turn limits, then 45 degrees
		add_req(FUNC_ATAN2, 32'h8000_0001, 32'h0000_0001);
		add_req(FUNC_ATAN2, 32'h8000_0001, 32'hffff_ffff);
		add_req(FUNC_ATAN2, 32'h0001_0000, 32'h0001_0000);
		for (int n = 0; n < RANDOM_REQS; n++) begin
			add_req($urandom_range(0, 1) ? FUNC_ATAN2 : FUNC_ATAN, random_operand(),
				random_operand());
		end
		total_reqs = pending_reqs.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted_cnt != total_reqs || expected_angles.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_cnt == 0 && expected_angles.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("tb_top: FAIL");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("tb_top: FAIL");
		$finish;
	end

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.func <= FUNC_ATAN;
			req.first_value <= '0;
			req.second_value <= '0;
			accepted_cnt <= 0;
			send_gap <= 0;
			send_phase_cnt <= 0;
			send_idle_ok <= 1'b0;
		end else begin
			if (send_phase_cnt == 0) begin
				send_idle_ok <= $urandom_range(0, 3) != 0;
				send_phase_cnt <= $urandom_range(50, 300);
			end else begin
				send_phase_cnt <= send_phase_cnt - 1;
			end
			if (req.valid && req.ready) begin
				expected_angles.push_back(predict_angle(pending_reqs[0]));
				void'(pending_reqs.pop_front());
				accepted_cnt <= accepted_cnt + 1;
			end
			if (req.valid && !req.ready) begin
				// hold the offered request
			end else if (send_gap != 0) begin
				req.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_reqs.size() == 0 ||
				(pending_reqs[0].hold_for_drain && expected_angles.size() != 0)) begin
				req.valid <= 1'b0;
			end else if (!quiet && send_idle_ok && $urandom_range(0, 9) == 0) begin
				req.valid <= 1'b0;
				send_gap <= $urandom_range(0, 10);
			end else begin
				req.valid <= 1'b1;
				req.func <= pending_reqs[0].func;
				req.first_value <= pending_reqs[0].first_value;
				req.second_value <= pending_reqs[0].second_value;
			end
		end
	end

	// result monitor and back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			fail_cnt = 0;
			hold_cnt <= 0;
			rcv_phase_cnt <= 0;
			rcv_idle_ok <= 1'b0;
			long_hold_done <= 1'b0;
		end else begin
			if (rcv_phase_cnt == 0) begin
				rcv_idle_ok <= $urandom_range(0, 3) != 0;
				rcv_phase_cnt <= $urandom_range(50, 300);
			end else begin
				rcv_phase_cnt <= rcv_phase_cnt - 1;
			end
			if (rsp.valid && rsp.ready) begin
				if (expected_angles.size() == 0) begin
					$error("angle_deg: expected none, got %0d", rsp.angle_deg);
					fail_cnt++;
				end else begin
					angle_want = expected_angles.pop_front();
					if (rsp.angle_deg !== angle_want) begin
						$error("angle_deg: expected %0d, got %0d", angle_want,
							rsp.angle_deg);
						fail_cnt++;
					end
				end
			end
			if (hold_cnt != 0) begin
				rsp.ready <= 1'b0;
				hold_cnt <= hold_cnt - 1;
			end else if (!long_hold_done && accepted_cnt >= LONG_HOLD_AT) begin
				// long stall so the pipeline fills and blocks requests
				rsp.ready <= 1'b0;
				hold_cnt <= LONG_HOLD_CYCLES - 1;
				long_hold_done <= 1'b1;
			end else if (!quiet && rcv_idle_ok && $urandom_range(0, 9) == 0) begin
				rsp.ready <= 1'b0;
				hold_cnt <= $urandom_range(0, 10);
			end else begin
				rsp.ready <= 1'b1;
			end
		end
	end

endmodule
